// ===== sv/fixed_point_exp_taylor_core_macros.svh =====
// Assertion macros for the fixed-point exponential core.
// Used by the checker that is bound to the top level; depends on nothing else.
`ifndef FIXED_POINT_EXP_TAYLOR_CORE_MACROS_SVH
`define FIXED_POINT_EXP_TAYLOR_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define FPEXP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that implies another one in the same cycle.
`define FPEXP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another one a fixed number of cycles later.
`define FPEXP_ASSERT_DELAY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== sv/fpexp_pkg.sv =====
// Shared types and constants of the fixed-point exponential core.
// Used by the clamp stage, the term stages and the top level; depends on nothing.
`default_nettype none

package fpexp_pkg;

	// Field widths of the operand and the result.
	localparam int XW      = 64;
	localparam int OUT_W   = 34;
	// Magnitudes of the operand and of a term never exceed 1.0 in Q32.32.
	localparam int FRAC_W  = 32;
	localparam int MAG_W   = FRAC_W + 1;
	// The running sum stays between 0 and about 2.72; a few guard bits cover it.
	localparam int SUM_W   = 36;
	// Divisors fit in six bits (up to 63) and the reciprocals reach 2^33.
	localparam int DIV_W   = 6;
	localparam int RECIP_W = FRAC_W + 2;

	localparam logic [MAG_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};

	// Word that travels down the term pipeline.
	typedef struct packed {
		logic                    xneg;
		logic [MAG_W-1:0]        xmag;
		logic                    tneg;
		logic [MAG_W-1:0]        tmag;
		logic signed [SUM_W-1:0] sum;
	} term_word_t;

endpackage

`default_nettype wire

// ===== sv/fixed_point_exp_taylor_core.sv =====
// Top level of the fixed-point exponential core: clamp stage, term pipeline, output.
// Depends on fpexp_pkg, fpexp_clamp and fpexp_term.
//
//   channel   ports                        handshake
//   input     x_value (signed Q32.32)      start, accepted while busy is low
//   output    exp_value (unsigned Q32.32)  done, one cycle, cannot be held off
//
// A word is accepted in every cycle; busy stays low.
// The path runs through one clamp stage, three stages per term
// (product, reciprocal divide, correction and sum) and one output register.
// Reset clears every valid bit, so words in flight are dropped.
`default_nettype none

module fixed_point_exp_taylor_core import fpexp_pkg::*; #(
	parameter int TERM_COUNT = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [XW-1:0] x_value,
	output logic                      done,
	output logic [OUT_W-1:0]          exp_value
);

	logic       valid_c [0:TERM_COUNT];
	term_word_t word_c  [0:TERM_COUNT];
	logic       done_q;
	logic [OUT_W-1:0] exp_q;

	// The pipeline never stalls.
	assign busy = 1'b0;

	fpexp_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.x_value   (x_value),
		.out_valid (valid_c[0]),
		.out_word  (word_c[0])
	);

	// One three-stage section for each term of the series.
	for (genvar i = 0; i < TERM_COUNT; i++) begin : g_term
		fpexp_term #(.N(i + 1)) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_word   (word_c[i]),
			.out_valid (valid_c[i+1]),
			.out_word  (word_c[i+1])
		);
	end

	// Output register; a negative sum reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[TERM_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		exp_q <= word_c[TERM_COUNT].sum[SUM_W-1] ? '0 : word_c[TERM_COUNT].sum[OUT_W-1:0];
	end

	assign done      = done_q;
	assign exp_value = exp_q;

endmodule

`default_nettype wire

// ===== sv/fpexp_clamp.sv =====
// Input stage: takes the operand apart into sign and magnitude and clamps it to 1.0.
// Depends on fpexp_pkg.
`default_nettype none

module fpexp_clamp import fpexp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [XW-1:0] x_value,
	output logic                      out_valid,
	output term_word_t                out_word
);

	logic          valid_s1;
	term_word_t    word_s1;
	logic          xneg;
	logic [XW-1:0] neg_raw;
	logic [XW-1:0] mag_full;
	logic          over_one;
	term_word_t    word_in;

	// Sign and magnitude; the most negative value lands above 1.0 and clamps too.
	assign xneg     = x_value[XW-1];
	assign neg_raw  = ~x_value + XW'(1);
	assign mag_full = xneg ? neg_raw : x_value;
	assign over_one = mag_full > XW'(Q_ONE);

	// The series starts with term = sum = 1.0.
	always_comb begin
		word_in.xneg = xneg;
		word_in.xmag = over_one ? Q_ONE : mag_full[MAG_W-1:0];
		word_in.tneg = 1'b0;
		word_in.tmag = Q_ONE;
		word_in.sum  = $signed({{(SUM_W-MAG_W){1'b0}}, Q_ONE});
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		word_s1 <= word_in;
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

`default_nettype wire

// ===== sv/fpexp_term.sv =====
// One term of the series in three register stages: product, reciprocal divide, sum.
// Depends on fpexp_pkg; N is the index of the term and the divisor.
`default_nettype none

module fpexp_term import fpexp_pkg::*; #(
	parameter int N = 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire term_word_t in_word,
	output logic            out_valid,
	output term_word_t      out_word
);

	// floor(2^33 / N): with the term below 2^33 the estimate is low by at most one.
	localparam logic [RECIP_W-1:0] RECIP   =
		RECIP_W'((68'd1 << (FRAC_W + 1)) / N);
	localparam logic [DIV_W-1:0]   DIVISOR = DIV_W'(N);

	logic                    valid_s1, valid_s2, valid_s3;
	term_word_t              word_s1, word_s2, word_s3;
	logic [2*FRAC_W-1:0]     prod_s1;
	logic [MAG_W-1:0]        qc_s2;
	logic [MAG_W-1:0]        approx_s2;
	logic                    neg_s2;

	logic [2*FRAC_W:0]       prod;
	logic                    x_one;
	logic [MAG_W-1:0]        q;
	logic                    rem_nz;
	logic                    rneg;
	logic [MAG_W-1:0]        qc;
	logic [MAG_W+RECIP_W-1:0] rprod;
	logic [MAG_W+DIV_W-1:0]  back_full;
	logic [MAG_W-1:0]        rem;
	logic                    step;
	logic [MAG_W-1:0]        quo;
	logic                    tneg_next;
	logic signed [SUM_W-1:0] quo_ext;
	term_word_t              word_next;

	// Stage 1: term times the operand; a magnitude of exactly 1.0 skips the product.
	assign prod = (2*FRAC_W+1)'(in_word.tmag) * (2*FRAC_W+1)'(in_word.xmag[FRAC_W-1:0]);

	// Stage 2: floor rounding of the shifted product, then the reciprocal estimate.
	assign x_one  = word_s1.xmag[MAG_W-1];
	assign q      = x_one ? word_s1.tmag : {1'b0, prod_s1[2*FRAC_W-1:FRAC_W]};
	assign rem_nz = !x_one && (prod_s1[FRAC_W-1:0] != '0);
	assign rneg   = word_s1.tneg ^ word_s1.xneg;
	assign qc     = q + MAG_W'(rneg && rem_nz);
	assign rprod  = (MAG_W+RECIP_W)'(qc) * (MAG_W+RECIP_W)'(RECIP);

	// Stage 3: one correction step of the quotient, then add or subtract it.
	assign back_full = (MAG_W+DIV_W)'(approx_s2) * (MAG_W+DIV_W)'(DIVISOR);
	assign rem       = qc_s2 - back_full[MAG_W-1:0];
	assign step      = rem >= MAG_W'(DIVISOR);
	assign quo       = approx_s2 + MAG_W'(step);
	assign tneg_next = neg_s2 && (quo != '0);
	assign quo_ext   = $signed({{(SUM_W-MAG_W){1'b0}}, quo});

	always_comb begin
		word_next      = word_s2;
		word_next.tneg = tneg_next;
		word_next.tmag = quo;
		word_next.sum  = tneg_next ? (word_s2.sum - quo_ext) : (word_s2.sum + quo_ext);
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload registers of the three stages.
	always_ff @(posedge clk) begin
		prod_s1   <= prod[2*FRAC_W-1:0];
		word_s1   <= in_word;
		qc_s2     <= qc;
		approx_s2 <= rprod[FRAC_W+1+MAG_W-1:FRAC_W+1];
		neg_s2    <= rneg;
		word_s2   <= word_s1;
		word_s3   <= word_next;
	end

	assign out_valid = valid_s3;
	assign out_word  = word_s3;

endmodule

`default_nettype wire

// ===== sv/fpexp_checker.sv =====
// Port-level checker of the fixed-point exponential core, with its bind statement.
// Depends on fixed_point_exp_taylor_core_macros.svh.
`default_nettype none

`include "fixed_point_exp_taylor_core_macros.svh"

module fpexp_checker #(
	parameter int LATENCY = 62
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [63:0] x_value,
	input wire logic        done,
	input wire logic [33:0] exp_value
);

	// Every accepted word comes out after the fixed latency.
	`FPEXP_ASSERT_DELAY(a_done_follows, start && !busy, LATENCY, done, "word lost in pipeline")

	// No result appears without a word accepted the latency before.
	`FPEXP_ASSERT_IMPLY(a_done_source, done, $past(start && !busy, LATENCY), "spurious result")

	// exp(0) is exactly 1.0.
	`FPEXP_ASSERT_IMPLY(a_exp_zero, done && $past(start && !busy && x_value == 64'd0, LATENCY), exp_value == 34'h100000000, "exp(0) is not 1.0")

	// Results stay inside exp of the clamped range.
	`FPEXP_ASSERT_IMPLY(a_range, done, exp_value != 34'd0 && exp_value <= 34'd11674931556, "result out of range")

endmodule

bind fixed_point_exp_taylor_core fpexp_checker #(
	.LATENCY (3 * TERM_COUNT + 2)
) u_fpexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.x_value   (x_value),
	.done      (done),
	.exp_value (exp_value)
);

`default_nettype wire
